// File: rtl/mlaq_pkg.sv
// Package for the multi-level alarm qualifier: shared widths, register indexes
// and the structs that carry configuration and per-level events between modules.
// No dependencies.
package mlaq_pkg;

   localparam int LEVELS     = 3;   // alarm levels built
   localparam int FIELD_W    = 3;   // width of each per-level event mask
   localparam int VALUE_W    = 16;
   localparam int TIME_W     = 32;
   localparam int HYST_W     = 15;
   localparam int COUNT_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD1    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD2    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD3    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ONSET_DELAY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_DELAY   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTION_DELAY  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVELS_IN_USE = 3'd7;

   typedef struct packed {
      logic [FIELD_W-1:0][VALUE_W-1:0] threshold;
      logic [HYST_W-1:0]               hysteresis;
      logic [TIME_W-1:0]               onset_delay;
      logic [TIME_W-1:0]               reset_delay;
      logic [TIME_W-1:0]               action_delay;
      logic [COUNT_W-1:0]              levels_in_use;
   } cfg_type;

   typedef struct packed {
      logic onset;
      logic action;
      logic clear;
      logic active;
   } lvl_event_type;

endpackage

// File: rtl/mlaq_csr.sv
// Configuration register file of the multi-level alarm qualifier.
// Depends on mlaq_pkg for register indexes and the cfg_type struct.
module mlaq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mlaq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mlaq_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mlaq_pkg::cfg_type                   cfg
);

   mlaq_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold[0]  <= 16'sd100;
         cfg_ff.threshold[1]  <= 16'sd150;
         cfg_ff.threshold[2]  <= 16'sd200;
         cfg_ff.hysteresis    <= 15'd10;
         cfg_ff.onset_delay   <= 32'd1000;
         cfg_ff.reset_delay   <= 32'd1000;
         cfg_ff.action_delay  <= 32'd5000;
         cfg_ff.levels_in_use <= 2'd3;
      end else if (csr_we) begin
         case (csr_index)
            mlaq_pkg::CSR_THRESHOLD1: begin
               cfg_ff.threshold[0] <= csr_wdata[mlaq_pkg::VALUE_W-1:0];
            end
            mlaq_pkg::CSR_THRESHOLD2: begin
               cfg_ff.threshold[1] <= csr_wdata[mlaq_pkg::VALUE_W-1:0];
            end
            mlaq_pkg::CSR_THRESHOLD3: begin
               cfg_ff.threshold[2] <= csr_wdata[mlaq_pkg::VALUE_W-1:0];
            end
            mlaq_pkg::CSR_HYSTERESIS: begin
               cfg_ff.hysteresis <= csr_wdata[mlaq_pkg::HYST_W-1:0];
            end
            mlaq_pkg::CSR_ONSET_DELAY: begin
               cfg_ff.onset_delay <= csr_wdata[mlaq_pkg::TIME_W-1:0];
            end
            mlaq_pkg::CSR_RESET_DELAY: begin
               cfg_ff.reset_delay <= csr_wdata[mlaq_pkg::TIME_W-1:0];
            end
            mlaq_pkg::CSR_ACTION_DELAY: begin
               cfg_ff.action_delay <= csr_wdata[mlaq_pkg::TIME_W-1:0];
            end
            mlaq_pkg::CSR_LEVELS_IN_USE: begin
               cfg_ff.levels_in_use <= csr_wdata[mlaq_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/mlaq_level.sv
// One alarm level: threshold and hysteresis compares, onset/action/reset timing
// and the level's state registers. Depends on mlaq_pkg.
module mlaq_level (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             evaluate,
   input  logic [mlaq_pkg::VALUE_W-1:0]     sample_value,
   input  logic [mlaq_pkg::TIME_W-1:0]      sample_time,
   input  logic [mlaq_pkg::TIME_W-1:0]      gap,
   input  logic [mlaq_pkg::VALUE_W-1:0]     threshold,
   input  mlaq_pkg::cfg_type                cfg,
   output mlaq_pkg::lvl_event_type          evt
);

   logic                          trig_ff, trig_in;
   logic                          res_ff, res_in;
   logic                          active_ff, active_in;
   logic                          done_ff, done_in;
   logic [mlaq_pkg::TIME_W-1:0]   trig_start_ff, trig_start_in;
   logic [mlaq_pkg::TIME_W-1:0]   res_start_ff, res_start_in;

   logic signed [mlaq_pkg::VALUE_W:0] value_x;
   logic signed [mlaq_pkg::VALUE_W:0] thr_x;
   logic signed [mlaq_pkg::VALUE_W:0] low_x;
   logic                              above;
   logic                              below;
   logic [mlaq_pkg::TIME_W-1:0]       trig_elapsed;
   logic [mlaq_pkg::TIME_W-1:0]       res_elapsed;
   logic                              onset_ev;
   logic                              action_ev;
   logic                              clear_ev;

   // Compare in 17 bits so that threshold minus hysteresis cannot wrap.
   assign value_x = $signed({sample_value[mlaq_pkg::VALUE_W-1], sample_value});
   assign thr_x   = $signed({threshold[mlaq_pkg::VALUE_W-1], threshold});
   assign low_x   = thr_x - $signed({2'b00, cfg.hysteresis});
   assign above   = value_x >= thr_x;
   assign below   = value_x < low_x;

   // A trigger starts now when the level is idle, so elapsed time then is zero.
   assign trig_elapsed = (!trig_ff && !active_ff) ? '0 : sample_time - trig_start_ff;
   assign res_elapsed  = (!res_ff && active_ff) ? '0 : sample_time - res_start_ff;

   always_comb begin
      trig_in       = trig_ff;
      res_in        = res_ff;
      active_in     = active_ff;
      done_in       = done_ff;
      trig_start_in = trig_start_ff;
      res_start_in  = res_start_ff;
      onset_ev      = 1'b0;
      action_ev     = 1'b0;
      clear_ev      = 1'b0;
      if (evaluate && above) begin
         if (res_ff) begin
            // A pending reset pauses while the value is back above threshold.
            res_start_in = res_start_ff + gap;
         end else begin
            if (!trig_ff && !active_ff) begin
               trig_in       = 1'b1;
               trig_start_in = sample_time;
            end
            if (!active_ff && trig_elapsed >= cfg.onset_delay) begin
               active_in = 1'b1;
               res_in    = 1'b0;
               trig_in   = 1'b0;
               done_in   = 1'b0;
               onset_ev  = 1'b1;
            end
            if (active_in && !done_in && trig_elapsed >= cfg.action_delay) begin
               done_in   = 1'b1;
               action_ev = 1'b1;
            end
         end
      end else if (evaluate && below) begin
         if (trig_ff) begin
            trig_start_in = trig_start_ff + gap;
         end else begin
            if (!res_ff && active_ff) begin
               res_in       = 1'b1;
               res_start_in = sample_time;
            end
            if (active_ff && res_elapsed >= cfg.reset_delay) begin
               active_in = 1'b0;
               trig_in   = 1'b0;
               res_in    = 1'b0;
               clear_ev  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff       <= 1'b0;
         res_ff        <= 1'b0;
         active_ff     <= 1'b0;
         done_ff       <= 1'b0;
         trig_start_ff <= '0;
         res_start_ff  <= '0;
      end else if (advance) begin
         trig_ff       <= trig_in;
         res_ff        <= res_in;
         active_ff     <= active_in;
         done_ff       <= done_in;
         trig_start_ff <= trig_start_in;
         res_start_ff  <= res_start_in;
      end
   end

   assign evt.onset  = onset_ev;
   assign evt.action = action_ev;
   assign evt.clear  = clear_ev;
   assign evt.active = active_in;

   a_onset_sets_active: assert property (@(posedge clock) disable iff (reset)
      advance && onset_ev |=> active_ff && !trig_ff && !res_ff)
      else $error("onset transfer did not leave the level active");

   a_clear_idles: assert property (@(posedge clock) disable iff (reset)
      advance && clear_ev |=> !active_ff && !trig_ff && !res_ff)
      else $error("cleared level still holds a pending timer");

   a_action_once: assert property (@(posedge clock) disable iff (reset)
      advance && action_ev |=> done_ff && active_ff)
      else $error("action fired without marking the level done");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(active_ff) && $stable(trig_start_ff) && $stable(res_start_ff))
      else $error("level state changed without a sample transfer");

endmodule

// File: rtl/multi_level_alarm_qualifier_top.sv
// Top level of the multi-level alarm qualifier: input register, per-level
// logic, result register. Depends on mlaq_pkg, mlaq_csr and mlaq_level.
//
// Usage:
//   Each transfer on the req_ channel carries one sensor sample and its tick
//   time. Each sample yields exactly one transfer on the rsp_ channel holding
//   the onset, action and reset event masks and the active level mask.
//   Configuration is written through csr_we/csr_index/csr_wdata, one register
//   per cycle, while no sample is in flight.
// Pipeline:
//   A sample is registered on acceptance and its result is registered in the
//   result register once the result slot is free. One sample per cycle is
//   sustained while rsp_tready stays high; the per-level compares and 32-bit
//   time differences run combinationally between the two registers.
// Reset:
//   Synchronous reset clears all level state and the previous sample time,
//   loads the register defaults and empties both pipeline registers.
// Stalls:
//   While rsp_tready is low the result holds, one more sample can wait in
//   the input register, and req_tready falls once both are full.
module multi_level_alarm_qualifier_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] sample_value, [47:16] sample_time
   input  logic [mlaq_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] onset_events, [5:3] action_events, [8:6] reset_events,
   // [11:9] active_levels, [15:12] zero
   output logic [mlaq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [mlaq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mlaq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FW = mlaq_pkg::FIELD_W;

   mlaq_pkg::cfg_type                   cfg;
   logic                                s1_valid_ff;
   logic [mlaq_pkg::VALUE_W-1:0]        s1_value_ff;
   logic [mlaq_pkg::TIME_W-1:0]         s1_time_ff;
   logic [mlaq_pkg::TIME_W-1:0]         prev_time_ff;
   logic                                rsp_valid_ff;
   logic [mlaq_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                                advance;
   logic [mlaq_pkg::TIME_W-1:0]         gap;
   logic [FW-1:0]                       onset_mask, action_mask, clear_mask, active_mask;

   mlaq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The sample in the input register moves on whenever the result slot frees.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign gap        = s1_time_ff - prev_time_ff;

   for (genvar i = 0; i < FW; i++) begin : g_level
      if (i < mlaq_pkg::LEVELS) begin : g_used
         mlaq_pkg::lvl_event_type evt;

         mlaq_level u_level (
            .clock        (clock),
            .reset        (reset),
            .advance      (advance),
            .evaluate     (cfg.levels_in_use > mlaq_pkg::COUNT_W'(i)),
            .sample_value (s1_value_ff),
            .sample_time  (s1_time_ff),
            .gap          (gap),
            .threshold    (cfg.threshold[i]),
            .cfg          (cfg),
            .evt          (evt)
         );

         assign onset_mask[i]  = evt.onset;
         assign action_mask[i] = evt.action;
         assign clear_mask[i]  = evt.clear;
         assign active_mask[i] = evt.active;
      end else begin : g_unused
         assign onset_mask[i]  = 1'b0;
         assign action_mask[i] = 1'b0;
         assign clear_mask[i]  = 1'b0;
         assign active_mask[i] = 1'b0;
      end
   end

   assign rsp_data_in = {{(mlaq_pkg::RSP_DATA_W - 4*FW){1'b0}},
                         active_mask, clear_mask, action_mask, onset_mask};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_time_ff <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            prev_time_ff <= s1_time_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_value_ff <= req_tdata[mlaq_pkg::VALUE_W-1:0];
         s1_time_ff  <= req_tdata[mlaq_pkg::VALUE_W +: mlaq_pkg::TIME_W];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for multi_level_alarm_qualifier_top: drives sensor samples
// on the req_ stream, predicts the per-level alarm events and compares every rsp_
// transfer against them. Depends on mlaq_pkg and the RTL of the block.
module tb_top;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 80;
   localparam int EXP_DEPTH   = 1024;

   typedef struct packed {
      logic [mlaq_pkg::LEVELS-1:0][mlaq_pkg::VALUE_W-1:0] threshold;
      logic [mlaq_pkg::HYST_W-1:0]                        hysteresis;
      logic [mlaq_pkg::TIME_W-1:0]                        onset_delay;
      logic [mlaq_pkg::TIME_W-1:0]                        clear_delay;
      logic [mlaq_pkg::TIME_W-1:0]                        action_delay;
      logic [mlaq_pkg::COUNT_W-1:0]                       levels;
   } alarm_settings_type;

   typedef struct packed {
      logic [mlaq_pkg::FIELD_W-1:0] active;
      logic [mlaq_pkg::FIELD_W-1:0] cleared;
      logic [mlaq_pkg::FIELD_W-1:0] action;
      logic [mlaq_pkg::FIELD_W-1:0] onset;
   } alarm_result_type;

   typedef enum {SIDE_ABOVE, SIDE_BELOW, SIDE_BAND, SIDE_NOISE} sample_side_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [mlaq_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [mlaq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [mlaq_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mlaq_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the configuration and the per-level state.
   alarm_settings_type                  cfg;
   logic [mlaq_pkg::LEVELS-1:0]         lvl_triggering;
   logic [mlaq_pkg::LEVELS-1:0]         lvl_resetting;
   logic [mlaq_pkg::LEVELS-1:0]         lvl_active;
   logic [mlaq_pkg::LEVELS-1:0]         lvl_action_done;
   logic [mlaq_pkg::LEVELS-1:0][31:0]   trigger_start;
   logic [mlaq_pkg::LEVELS-1:0][31:0]   clear_start;
   logic [31:0]                         last_stamp;

   // Expected results wait in a ring; the write count runs ahead of the read count.
   alarm_result_type expected_alarms[EXP_DEPTH];
   int               exp_wr = 0;
   int               exp_rd = 0;
   int               mismatch_count = 0;
   logic [31:0]      tick_now = '0;

   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;
   bit long_hold_req = 1'b0;
   int rx_hold_left = 0;
   int rx_run_left = 0;
   bit rx_level = 1'b0;
   int stall_cycles = 0;

   multi_level_alarm_qualifier_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void reset_model();
      cfg.threshold[0]  = 16'd100;
      cfg.threshold[1]  = 16'd150;
      cfg.threshold[2]  = 16'd200;
      cfg.hysteresis    = 15'd10;
      cfg.onset_delay   = 32'd1000;
      cfg.clear_delay   = 32'd1000;
      cfg.action_delay  = 32'd5000;
      cfg.levels        = 2'd3;
      lvl_triggering    = '0;
      lvl_resetting     = '0;
      lvl_active        = '0;
      lvl_action_done   = '0;
      trigger_start     = '0;
      clear_start       = '0;
      last_stamp        = '0;
   endfunction

   function automatic void apply_csr(input logic [mlaq_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [mlaq_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         mlaq_pkg::CSR_THRESHOLD1:    cfg.threshold[0] = value[15:0];
         mlaq_pkg::CSR_THRESHOLD2:    cfg.threshold[1] = value[15:0];
         mlaq_pkg::CSR_THRESHOLD3:    cfg.threshold[2] = value[15:0];
         mlaq_pkg::CSR_HYSTERESIS:    cfg.hysteresis = value[mlaq_pkg::HYST_W-1:0];
         mlaq_pkg::CSR_ONSET_DELAY:   cfg.onset_delay = value;
         mlaq_pkg::CSR_RESET_DELAY:   cfg.clear_delay = value;
         mlaq_pkg::CSR_ACTION_DELAY:  cfg.action_delay = value;
         mlaq_pkg::CSR_LEVELS_IN_USE: cfg.levels = value[mlaq_pkg::COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic alarm_result_type qualify_sample(input logic signed [15:0] value,
                                                       input logic [31:0] stamp);
      alarm_result_type r;
      logic [31:0]      gap;
      logic [31:0]      elapsed;
      int               val_i;
      int               thr_i;
      int               low_i;
      int               count;
      r = '0;
      val_i = value;
      gap = stamp - last_stamp;
      count = cfg.levels;
      if (count > mlaq_pkg::LEVELS) count = mlaq_pkg::LEVELS;
      for (int i = 0; i < count; i++) begin
         thr_i = $signed(cfg.threshold[i]);
         low_i = thr_i - int'(cfg.hysteresis);
         if (val_i >= thr_i) begin
            // A pending clear pauses while the value is back above threshold.
            if (lvl_resetting[i]) begin
               clear_start[i] = clear_start[i] + gap;
            end else begin
               if (!lvl_triggering[i] && !lvl_active[i]) begin
                  lvl_triggering[i] = 1'b1;
                  trigger_start[i] = stamp;
               end
               elapsed = stamp - trigger_start[i];
               if (!lvl_active[i] && elapsed >= cfg.onset_delay) begin
                  lvl_active[i] = 1'b1;
                  lvl_resetting[i] = 1'b0;
                  lvl_triggering[i] = 1'b0;
                  lvl_action_done[i] = 1'b0;
                  r.onset[i] = 1'b1;
               end
               if (lvl_active[i] && !lvl_action_done[i] && elapsed >= cfg.action_delay) begin
                  lvl_action_done[i] = 1'b1;
                  r.action[i] = 1'b1;
               end
            end
         end else if (val_i < low_i) begin
            if (lvl_triggering[i]) begin
               trigger_start[i] = trigger_start[i] + gap;
            end else begin
               if (!lvl_resetting[i] && lvl_active[i]) begin
                  lvl_resetting[i] = 1'b1;
                  clear_start[i] = stamp;
               end
               elapsed = stamp - clear_start[i];
               if (lvl_active[i] && elapsed >= cfg.clear_delay) begin
                  lvl_active[i] = 1'b0;
                  lvl_triggering[i] = 1'b0;
                  lvl_resetting[i] = 1'b0;
                  r.cleared[i] = 1'b1;
               end
            end
         end
      end
      last_stamp = stamp;
      for (int i = 0; i < mlaq_pkg::LEVELS; i++) r.active[i] = lvl_active[i];
      return r;
   endfunction

   function automatic void store_expected(input alarm_result_type r);
      expected_alarms[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic signed [15:0] clamp16(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic [31:0] advance(input int unsigned d);
      tick_now = tick_now + d;
      return tick_now;
   endfunction

   function automatic int unsigned random_delta();
      int roll;
      roll = $urandom_range(0, 39);
      if (roll == 0) return $urandom();
      if (roll == 1) return 0;
      return $urandom_range(1, 60);
   endfunction

   function automatic int pick_gap();
      int roll;
      if (sender_steady) return 0;
      roll = $urandom_range(0, 9);
      if (roll < 5) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] pick_delay();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 32'd0;
      if (roll == 1) return 32'hFFFF_FFFF;
      if (roll == 2) return $urandom();
      return $urandom_range(0, 250);
   endfunction

   function automatic alarm_settings_type make_settings(input int t0, input int t1,
                                                        input int t2, input int hyst,
                                                        input logic [31:0] onset,
                                                        input logic [31:0] clear,
                                                        input logic [31:0] action,
                                                        input int levels);
      alarm_settings_type s;
      s.threshold[0] = t0[15:0];
      s.threshold[1] = t1[15:0];
      s.threshold[2] = t2[15:0];
      s.hysteresis   = hyst[mlaq_pkg::HYST_W-1:0];
      s.onset_delay  = onset;
      s.clear_delay  = clear;
      s.action_delay = action;
      s.levels       = levels[mlaq_pkg::COUNT_W-1:0];
      return s;
   endfunction

   function automatic alarm_settings_type random_settings();
      alarm_settings_type s;
      int roll;
      logic [31:0] raw;
      for (int i = 0; i < mlaq_pkg::LEVELS; i++) begin
         roll = $urandom_range(0, 9);
         raw = $urandom();
         if (roll == 0) s.threshold[i] = 16'h8000;
         else if (roll == 1) s.threshold[i] = 16'h7FFF;
         else if (roll == 2) s.threshold[i] = raw[15:0];
         else s.threshold[i] = clamp16(int'($urandom_range(0, 600)) - 300);
      end
      roll = $urandom_range(0, 9);
      raw = $urandom();
      if (roll == 0) s.hysteresis = '0;
      else if (roll == 1) s.hysteresis = 15'h7FFF;
      else if (roll == 2) s.hysteresis = raw[mlaq_pkg::HYST_W-1:0];
      else s.hysteresis = 15'($urandom_range(0, 40));
      s.onset_delay  = pick_delay();
      s.clear_delay  = pick_delay();
      s.action_delay = pick_delay();
      roll = $urandom_range(0, 9);
      if (roll == 0) s.levels = 2'd0;
      else if (roll == 1) s.levels = 2'd1;
      else if (roll == 2) s.levels = 2'd2;
      else s.levels = 2'd3;
      return s;
   endfunction

   function automatic logic signed [15:0] pick_value(input int lvl,
                                                     input sample_side_type side);
      int thr;
      int low;
      logic [31:0] raw;
      thr = $signed(cfg.threshold[lvl]);
      low = thr - int'(cfg.hysteresis);
      raw = $urandom();
      case (side)
         SIDE_ABOVE: return clamp16(thr + int'($urandom_range(0, 40)));
         SIDE_BELOW: return clamp16(low - 1 - int'($urandom_range(0, 40)));
         SIDE_BAND: begin
            if (cfg.hysteresis == 0) return clamp16(thr);
            return clamp16(low + int'($urandom_range(0, int'(cfg.hysteresis) - 1)));
         end
         default: return raw[15:0];
      endcase
   endfunction

   // ---------------------------------------------------------------- bus tasks

   task automatic send_sample(input logic signed [15:0] value, input logic [31:0] stamp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {stamp, value};
      do @(posedge clock); while (!req_tready);
      store_expected(qualify_sample(value, stamp));
   endtask

   // Waits until every result is back and the pipeline has gone quiet.
   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [mlaq_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mlaq_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      apply_csr(idx, value);
   endtask

   // Unused upper bits of the narrow registers carry random bits that must be ignored.
   task automatic load_settings(input alarm_settings_type s);
      logic [31:0] junk;
      settle_pipeline();
      junk = $urandom();
      write_csr(mlaq_pkg::CSR_THRESHOLD1, {junk[31:16], s.threshold[0]});
      write_csr(mlaq_pkg::CSR_THRESHOLD2, {junk[15:0], s.threshold[1]});
      write_csr(mlaq_pkg::CSR_THRESHOLD3, {junk[23:8], s.threshold[2]});
      write_csr(mlaq_pkg::CSR_HYSTERESIS, {junk[16:0], s.hysteresis});
      write_csr(mlaq_pkg::CSR_ONSET_DELAY, s.onset_delay);
      write_csr(mlaq_pkg::CSR_RESET_DELAY, s.clear_delay);
      write_csr(mlaq_pkg::CSR_ACTION_DELAY, s.action_delay);
      write_csr(mlaq_pkg::CSR_LEVELS_IN_USE, {junk[29:0], s.levels});
      csr_we <= 1'b0;
   endtask

   // Runs of samples that hold one level above, below or inside its band, so that
   // timers get to run out, mixed with a little full-range noise.
   task automatic run_episodes(input int items);
      int sent;
      int len;
      int lvl;
      int roll;
      sample_side_type side;
      sent = 0;
      while (sent < items) begin
         lvl = $urandom_range(0, mlaq_pkg::LEVELS - 1);
         roll = $urandom_range(0, 19);
         if (roll < 9) side = SIDE_ABOVE;
         else if (roll < 15) side = SIDE_BELOW;
         else if (roll < 17) side = SIDE_BAND;
         else side = SIDE_NOISE;
         len = (side == SIDE_NOISE) ? $urandom_range(1, 3) : $urandom_range(1, 10);
         repeat (len) send_sample(pick_value(lvl, side), advance(random_delta()));
         sent += len;
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_default_sequence();
      send_sample(16'sh7FFF, 32'd500);
      send_sample(16'sd0, 32'd1000);      // below every reset point: triggers pause
      send_sample(16'sd95, 32'd1500);     // level one in its band, the others still paused
      send_sample(16'sd300, 32'd2600);    // onset on all levels
      send_sample(16'sd200, 32'd6000);    // level one reaches its action
      send_sample(16'sh8000, 32'd7000);   // clear timers start
      send_sample(16'sd250, 32'd7500);    // clear timers pause above threshold
      send_sample(16'sd195, 32'd8600);    // level three sits inside its band
      send_sample(-16'sd5, 32'd9600);     // all levels clear
      send_sample(16'sh7FFF, 32'hFFFF_FF00);
      send_sample(16'sh7FFF, 32'h0000_0300); // onset measured across the time wrap
      tick_now = 32'h0000_0300;
   endtask

   task automatic test_register_extremes();
      // Zero onset and action delays: both events come with the same sample.
      load_settings(make_settings(-32768, 32767, 0, 32767, 0, 32'hFFFF_FFFF, 0, 2));
      send_sample(16'sh8000, advance(5));
      send_sample(16'sh7FFF, advance(5));
      send_sample(-16'sd1, advance(5));
      send_sample(16'sd0, advance(5));
      load_settings(make_settings(100, -100, 32767, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 3));
      send_sample(16'sd99, advance(3));
      send_sample(16'sh7FFF, advance(3));
      send_sample(16'sh8000, advance(3));
      send_sample(16'sd100, advance(3));
      // No level evaluated; the active mask is still reported.
      load_settings(make_settings(100, -100, 32767, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0));
      send_sample(16'sh7FFF, advance(9));
      send_sample(16'sh8000, advance(9));
      load_settings(make_settings(-20, 0, 20, 5, 2, 2, 4, 1));
      send_sample(-16'sd20, advance(1));
      send_sample(-16'sd20, advance(3));
   endtask

   task automatic test_random_settings();
      repeat (6) begin
         load_settings(random_settings());
         run_episodes(55);
      end
   endtask

   task automatic test_output_backpressure();
      load_settings(random_settings());
      long_hold_req = 1'b1;
      sender_steady = 1'b1;
      run_episodes(40);
      sender_steady = 1'b0;
      settle_pipeline();
   endtask

   task automatic test_steady_stream();
      load_settings(random_settings());
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      run_episodes(60);
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      settle_pipeline();
   endtask

   // ---------------------------------------------------------------- receiver and checker

   always @(posedge clock) begin : rsp_ready_gen
      int roll;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         rx_hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_run_left == 0) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
               rx_level = 1'b1;
               rx_run_left = $urandom_range(1, 12);
            end else if (roll < 9) begin
               rx_level = 1'b0;
               rx_run_left = $urandom_range(1, 3);
            end else begin
               rx_level = 1'b0;
               rx_run_left = $urandom_range(8, 30);
            end
         end
         rx_run_left--;
         rsp_tready <= rx_level || receiver_steady;
      end
   end

   task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      alarm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_wr == exp_rd) begin
            mismatch_count++;
            $display("%0t: unexpected result transfer, expected none, actual %0h",
                     $time, rsp_tdata);
         end else begin
            want = expected_alarms[exp_rd % EXP_DEPTH];
            exp_rd++;
            check_field("onset_events", {1'b0, want.onset}, {1'b0, rsp_tdata[2:0]});
            check_field("action_events", {1'b0, want.action}, {1'b0, rsp_tdata[5:3]});
            check_field("reset_events", {1'b0, want.cleared}, {1'b0, rsp_tdata[8:6]});
            check_field("active_levels", {1'b0, want.active}, {1'b0, rsp_tdata[11:9]});
            check_field("padding", 4'h0, rsp_tdata[15:12]);
         end
      end
   end

   // Ends the run when nothing has moved for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL multi_level_alarm_qualifier_top");
            $finish;
         end
      end
   end

   initial begin
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_default_sequence();
      test_register_extremes();
      test_random_settings();
      test_output_backpressure();
      test_steady_stream();
      settle_pipeline();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS multi_level_alarm_qualifier_top");
      end else begin
         $display("FAIL multi_level_alarm_qualifier_top");
      end
      $finish;
   end

endmodule
